FILE: hw/rtl/lsf_pkg.sv
// Shared constants, codes and types of the five-point Laplacian filter.
// Used by the channel interfaces and by every lsf_* module; depends on nothing.
package lsf_pkg;

  // Frame geometry and sample format
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = 11;

  // Arithmetic: second differences, Q4.20 coefficients, products and sum
  localparam int COEF_W    = 24;
  localparam int FRAC_BITS = 20;
  localparam int DIFF_W    = SAMPLE_BITS + 2;
  localparam int PROD_W    = DIFF_W + COEF_W + 1;
  localparam int SUM_W     = PROD_W + 1;
  localparam int QUO_W     = SUM_W - FRAC_BITS;
  localparam int OUT_W     = 32;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COEF_Z       = 2'd2;
  localparam logic [1:0] REG_COEF_X       = 2'd3;

  // Reset values
  localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(MAX_HEIGHT);
  localparam logic [COEF_W-1:0] COEF_RST   = COEF_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [COEF_W-1:0] coef_z;
    logic [COEF_W-1:0] coef_x;
  } cfg_t;

  // One result request: both second differences (zero at the border) and the
  // end-of-frame mark
  typedef struct packed {
    logic signed [DIFF_W-1:0] dv;
    logic signed [DIFF_W-1:0] dh;
    logic                     eof;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_beat_t;

endpackage

FILE: hw/rtl/lsf_if.sv
// Valid/ready channel interfaces of the Laplacian filter: sample input and
// result output. Depends on lsf_pkg for the payload widths.
interface lsf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    command;
  logic signed [lsf_pkg::SAMPLE_BITS-1:0]  sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);
endinterface

interface lsf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lsf_pkg::OUT_W-1:0]  laplacian;
  logic                              end_of_frame;

  modport source (output valid, output laplacian, output end_of_frame, input ready);
  modport sink   (input valid, input laplacian, input end_of_frame, output ready);
endinterface

FILE: hw/rtl/lsf_regs.sv
// Configuration registers behind the APB-style port: frame geometry and
// the two Q4.20 coefficients. Depends on lsf_pkg.
module lsf_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lsf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output lsf_pkg::cfg_t                    cfg
);

  lsf_pkg::cfg_t                  cfg_r;
  logic                           wr_en;
  logic [1:0]                     reg_idx;
  logic [lsf_pkg::DIM_W-1:0]      dim_raw;
  logic [lsf_pkg::DIM_W-1:0]      width_clamped;
  logic [lsf_pkg::DIM_W-1:0]      height_clamped;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign dim_raw = pwdata[lsf_pkg::DIM_W-1:0];

  // Saturate geometry to the supported range
  always_comb begin
    width_clamped = dim_raw;
    if (dim_raw < lsf_pkg::DIM_W'(3)) begin
      width_clamped = lsf_pkg::DIM_W'(3);
    end else if (dim_raw > lsf_pkg::WIDTH_RST) begin
      width_clamped = lsf_pkg::WIDTH_RST;
    end
    height_clamped = dim_raw;
    if (dim_raw < lsf_pkg::DIM_W'(3)) begin
      height_clamped = lsf_pkg::DIM_W'(3);
    end else if (dim_raw > lsf_pkg::HEIGHT_RST) begin
      height_clamped = lsf_pkg::HEIGHT_RST;
    end
  end

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= lsf_pkg::WIDTH_RST;
      cfg_r.frame_height <= lsf_pkg::HEIGHT_RST;
      cfg_r.coef_z       <= lsf_pkg::COEF_RST;
      cfg_r.coef_x       <= lsf_pkg::COEF_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lsf_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= width_clamped;
        lsf_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= height_clamped;
        lsf_pkg::REG_COEF_Z:       cfg_r.coef_z <= pwdata[lsf_pkg::COEF_W-1:0];
        lsf_pkg::REG_COEF_X:       cfg_r.coef_x <= pwdata[lsf_pkg::COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      lsf_pkg::REG_FRAME_WIDTH:  prdata = lsf_pkg::CFG_DATA_W'(cfg_r.frame_width);
      lsf_pkg::REG_FRAME_HEIGHT: prdata = lsf_pkg::CFG_DATA_W'(cfg_r.frame_height);
      lsf_pkg::REG_COEF_Z:       prdata = lsf_pkg::CFG_DATA_W'(cfg_r.coef_z);
      lsf_pkg::REG_COEF_X:       prdata = lsf_pkg::CFG_DATA_W'(cfg_r.coef_x);
      default:                   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/lsf_front.sv
// Front end: accepts sample and drain items, tracks the raster position,
// keeps the two line memories and forms both second differences.
// Depends on lsf_pkg and lsf_in_if.
module lsf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  lsf_in_if.sink                           in_chan,
  input  lsf_pkg::cfg_t                    cfg,
  input  logic [lsf_pkg::FIFO_CNT_W-1:0]   fifo_count,
  output lsf_pkg::op_beat_t                push
);

  localparam int SB = lsf_pkg::SAMPLE_BITS;
  localparam int DW = lsf_pkg::DIFF_W;

  // Line memories: previous row and the row before it
  logic signed [SB-1:0] line_a [lsf_pkg::MAX_WIDTH];
  logic signed [SB-1:0] line_b [lsf_pkg::MAX_WIDTH];

  logic [lsf_pkg::COL_W-1:0] col_r, col_nxt, col_p1;
  logic [lsf_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [lsf_pkg::DIM_W-1:0] drain_r, drain_nxt;
  logic [lsf_pkg::DIM_W-1:0] col_ext_p1, row_ext, row_ext_p1;

  logic accept, is_drain, pend, take_drain, take_smp;
  logic col_last, row_last, interior;
  logic [lsf_pkg::FIFO_CNT_W:0] room_need;

  // Stage 1 (memory read data valid)
  logic                      s1_push_r;
  logic                      s1_wrb_r;
  logic                      s1_zero_r;
  logic                      s1_eof_r;
  logic signed [SB-1:0]      s1_smp_r;
  logic [lsf_pkg::COL_W-1:0] s1_col_r;
  logic signed [SB-1:0]      mid_q, right_q, up_q;
  logic signed [SB-1:0]      left_r;

  logic signed [DW-1:0] up_x, mid_x, right_x, left_x, smp_x, dv, dh;

  // Hold input whenever the queue could not take one more request
  assign room_need = {1'b0, fifo_count} + {{lsf_pkg::FIFO_CNT_W{1'b0}}, s1_push_r};
  assign in_chan.ready = room_need < (lsf_pkg::FIFO_CNT_W + 1)'(lsf_pkg::FIFO_DEPTH);

  // Classify the item
  assign accept     = in_chan.valid && in_chan.ready;
  assign is_drain   = in_chan.command == lsf_pkg::CMD_DRAIN;
  assign pend       = drain_r != '0;
  assign take_drain = accept && is_drain && pend;
  assign take_smp   = accept && !is_drain && !pend;

  assign col_p1     = col_r + 1'b1;
  assign col_ext_p1 = lsf_pkg::DIM_W'(col_r) + 1'b1;
  assign row_ext    = lsf_pkg::DIM_W'(row_r);
  assign row_ext_p1 = row_ext + 1'b1;
  assign col_last   = col_ext_p1 >= cfg.frame_width;
  assign row_last   = row_ext_p1 >= cfg.frame_height;
  assign interior   = (row_r >= lsf_pkg::ROW_W'(2)) && (row_ext < cfg.frame_height) &&
                      (col_r != '0) && (col_ext_p1 < cfg.frame_width) &&
                      (col_r != lsf_pkg::COL_W'(lsf_pkg::MAX_WIDTH - 1));

  // Advance position and drain count
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    if (take_drain) begin
      drain_nxt = drain_r - 1'b1;
    end else if (take_smp) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt   = '0;
          drain_nxt = cfg.frame_width;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      drain_r   <= '0;
      s1_push_r <= 1'b0;
      s1_wrb_r  <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      drain_r   <= drain_nxt;
      s1_push_r <= take_drain || (take_smp && (row_r != '0));
      s1_wrb_r  <= take_smp;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_zero_r <= take_drain || !interior;
      s1_eof_r  <= take_drain && (drain_r == lsf_pkg::DIM_W'(1));
      s1_smp_r  <= in_chan.sample;
      s1_col_r  <= col_r;
    end
  end

  // Previous row: read center and right neighbor, store the new sample
  always_ff @(posedge clk) begin
    if (take_smp) begin
      mid_q          <= line_a[col_r];
      right_q        <= line_a[col_p1];
      line_a[col_r]  <= in_chan.sample;
    end
  end

  // Row before: read the upper tap, then shift the old center down
  always_ff @(posedge clk) begin
    if (take_smp) begin
      up_q <= line_b[col_r];
    end
    if (s1_wrb_r) begin
      line_b[s1_col_r] <= mid_q;
    end
  end

  // Left tap follows the center of the previous sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s1_wrb_r) begin
      left_r <= mid_q;
    end
  end

  // Second differences
  assign up_x    = {{(DW-SB){up_q[SB-1]}}, up_q};
  assign mid_x   = {{(DW-SB){mid_q[SB-1]}}, mid_q};
  assign right_x = {{(DW-SB){right_q[SB-1]}}, right_q};
  assign left_x  = {{(DW-SB){left_r[SB-1]}}, left_r};
  assign smp_x   = {{(DW-SB){s1_smp_r[SB-1]}}, s1_smp_r};
  assign dv      = up_x + smp_x - (mid_x <<< 1);
  assign dh      = left_x + right_x - (mid_x <<< 1);

  assign push.valid  = s1_push_r;
  assign push.op.dv  = s1_zero_r ? '0 : dv;
  assign push.op.dh  = s1_zero_r ? '0 : dh;
  assign push.op.eof = s1_eof_r;

`ifndef SYNTHESIS
  a_frame_end_loads_drain: assert property (@(posedge clk) disable iff (!rst_n)
    take_smp && col_last && row_last |=> drain_r == $past(cfg.frame_width))
    else $error("drain count not loaded at frame end");

  a_eof_on_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_push_r && s1_eof_r |-> drain_r == '0)
    else $error("end of frame marked while drain results remain");
`endif

endmodule

FILE: hw/rtl/lsf_fifo.sv
// Short request queue between front and back so that each side stalls on its
// own. Depends on lsf_pkg.
module lsf_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lsf_pkg::op_beat_t                push,
  input  logic                             pop,
  output lsf_pkg::op_beat_t                head,
  output logic [lsf_pkg::FIFO_CNT_W-1:0]   count
);

  lsf_pkg::op_t                   entry_r [lsf_pkg::FIFO_DEPTH];
  logic [lsf_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [lsf_pkg::FIFO_CNT_W-1:0] count_r;

  // Store on push
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.op;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push.valid && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push.valid && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head.valid = count_r != '0;
  assign head.op    = entry_r[rd_ptr_r];
  assign count      = count_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (count_r < lsf_pkg::FIFO_CNT_W'(lsf_pkg::FIFO_DEPTH)) || pop)
    else $error("request queue overflow");
`endif

endmodule

FILE: hw/rtl/lsf_back.sv
// Back end: weights both second differences by their coefficients, sums,
// rounds and drives the result register. Depends on lsf_pkg and lsf_out_if.
module lsf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lsf_pkg::op_beat_t   head,
  output logic                pop,
  input  lsf_pkg::cfg_t       cfg,
  lsf_out_if.source           out_chan
);

  localparam int PW = lsf_pkg::PROD_W;
  localparam int SW = lsf_pkg::SUM_W;
  localparam int QW = lsf_pkg::QUO_W;
  localparam int OW = lsf_pkg::OUT_W;
  localparam int FB = lsf_pkg::FRAC_BITS;

  logic                 adv;
  logic                 m_valid_r;
  logic                 m_eof_r;
  logic signed [PW-1:0] pz_r, px_r, pz_nxt, px_nxt;
  logic        [SW-1:0] sum_rnd;
  logic        [QW-1:0] quo;
  logic                 out_valid_r;
  logic signed [OW-1:0] out_lap_r;
  logic                 out_eof_r;

  // Advance the whole pipe unless the result register is held
  assign adv = !out_valid_r || out_chan.ready;
  assign pop = adv && head.valid;

  // Products
  assign pz_nxt = $signed(head.op.dv) * $signed({1'b0, cfg.coef_z});
  assign px_nxt = $signed(head.op.dh) * $signed({1'b0, cfg.coef_x});

  // Sum with half bias, then drop the fraction (floor)
  assign sum_rnd = {pz_r[PW-1], pz_r} + {px_r[PW-1], px_r} +
                   {{(SW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  assign quo     = sum_rnd[SW-1:FB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r   <= head.valid;
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pz_r    <= pz_nxt;
      px_r    <= px_nxt;
      m_eof_r <= head.op.eof;
    end
  end

  // The rounded sum always fits the result, so widen by sign
  always_ff @(posedge clk) begin
    if (adv && m_valid_r) begin
      out_lap_r <= {{(OW-QW){quo[QW-1]}}, quo};
      out_eof_r <= m_eof_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.laplacian    = out_lap_r;
  assign out_chan.end_of_frame = out_eof_r;

`ifndef SYNTHESIS
  a_eof_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eof_r |-> out_lap_r == '0)
    else $error("end-of-frame result is not a border zero");
`endif

endmodule

FILE: hw/rtl/laplacian_stencil_filter.sv
// Top level of the five-point Laplacian filter: registers, front end, request
// queue and back end. Depends on lsf_pkg, lsf_if and all lsf_* modules.
//
// Usage:
//   in_chan carries one item per request: command SAMPLE with a signed sample
//   in raster order, or command DRAIN. The result for row r-1 appears while
//   row r streams in; the last row of zeros comes from one DRAIN item per
//   column, and the final one carries end_of_frame. Samples sent while drain
//   results are pending, and drains sent when none are pending, are dropped.
//   out_chan carries laplacian and end_of_frame.
//   Geometry and coefficients are written on the APB port (psel ... pready,
//   pready always high) while the block is idle.
// Timing:
//   One item per cycle sustained while the receiver takes results. A result
//   leaves the output register after line-memory read, queue, multiply,
//   then sum and round.
// Reset (rst_n low, synchronous): position, drain count, queue and pipeline
//   valid bits clear; registers return to 1024 x 1024 and unit coefficients.
//   Line memories are not cleared: the first row only writes them.
// Receiver stall: the result register holds; the back pipe stops; the queue
//   of four requests keeps taking items until full, then in_chan.ready drops.
module laplacian_stencil_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  lsf_in_if.sink                           in_chan,
  lsf_out_if.source                        out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lsf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  lsf_pkg::cfg_t                   cfg;
  lsf_pkg::op_beat_t               push;
  lsf_pkg::op_beat_t               head;
  logic                            pop;
  logic [lsf_pkg::FIFO_CNT_W-1:0]  fifo_count;

  lsf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg        (cfg),
    .fifo_count (fifo_count),
    .push       (push)
  );

  lsf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (fifo_count)
  );

  lsf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .cfg      (cfg),
    .out_chan (out_chan)
  );

endmodule
